// File: rtl/core/irpwd_pkg.sv
// ----------------------------------------------------------------------------
// irpwd_pkg
// Shared constants and types for the infrared pulse-width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package irpwd_pkg;

    // Number of data bits in one frame (8..32).
    localparam int CODE_BITS   = 32;
    localparam int TICK_W      = 16;
    localparam int CFG_INDEX_W = 4;
    localparam int RAW_W       = 32;
    localparam int COUNT_W     = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] CODE_COUNT = COUNT_W'(CODE_BITS);

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LEADER_MARK_LOW  = 4'd0,
        CFG_LEADER_SPACE_LOW = 4'd1,
        CFG_REPEAT_SPACE_LOW = 4'd2,
        CFG_LONG_WINDOW      = 4'd3,
        CFG_BIT_MARK_LOW     = 4'd4,
        CFG_ZERO_SPACE_LOW   = 4'd5,
        CFG_ONE_SPACE_LOW    = 4'd6,
        CFG_SHORT_WINDOW     = 4'd7
    } cfg_index_t;

    localparam logic [TICK_W-1:0] RST_LEADER_MARK_LOW  = 16'd4000;
    localparam logic [TICK_W-1:0] RST_LEADER_SPACE_LOW = 16'd2000;
    localparam logic [TICK_W-1:0] RST_REPEAT_SPACE_LOW = 16'd7000;
    localparam logic [TICK_W-1:0] RST_LONG_WINDOW      = 16'd1000;
    localparam logic [TICK_W-1:0] RST_BIT_MARK_LOW     = 16'd200;
    localparam logic [TICK_W-1:0] RST_ZERO_SPACE_LOW   = 16'd200;
    localparam logic [TICK_W-1:0] RST_ONE_SPACE_LOW    = 16'd800;
    localparam logic [TICK_W-1:0] RST_SHORT_WINDOW     = 16'd100;

    localparam logic [7:0] COMPLEMENT_MASK = 8'hff;

endpackage

`default_nettype wire

// File: rtl/core/ir_pulse_width_decoder.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder
// Decodes mark/space durations of NEC-style infrared frames into key events.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | edge_ticks
//  out     | output    | out_valid/out_stall| key_event, was_repeat, raw_code,
//          |           |                    | key_code, code_ok
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
//  One item per cycle while in_stall is low; each result appears in the cycle after its transfer,
//  set by the single decode stage ahead of the result register.
//  in_stall rises only while the result register is full and stalled.
//  cfg_ready is always high; writes to indexes above 7 are dropped.
//  Reset loads the default thresholds and clears the decode state.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_decoder (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [irpwd_pkg::TICK_W-1:0]      edge_ticks,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   key_event,
    output logic                                   was_repeat,
    output logic [irpwd_pkg::RAW_W-1:0]            raw_code,
    output logic [7:0]                             key_code,
    output logic                                   code_ok,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [irpwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [irpwd_pkg::TICK_W-1:0]      cfg_data
);

    localparam int TW = irpwd_pkg::TICK_W;
    localparam int CW = irpwd_pkg::COUNT_W;
    localparam int RW = irpwd_pkg::RAW_W;

    function automatic logic in_window(input logic [TW-1:0] v,
                                       input logic [TW-1:0] low,
                                       input logic [TW-1:0] win);
        logic [TW:0] upper;
        upper = {1'b0, low} + {1'b0, win};
        return (v > low) && ({1'b0, v} < upper);
    endfunction

    // configuration
    logic [TW-1:0] leader_mark_low_reg, leader_space_low_reg, repeat_space_low_reg;
    logic [TW-1:0] long_window_reg, bit_mark_low_reg, zero_space_low_reg;
    logic [TW-1:0] one_space_low_reg, short_window_reg;

    // decode state
    logic          phase_reg, phase_next;
    logic [TW-1:0] mark_reg, mark_next;
    logic [TW-1:0] space_reg, space_next;
    logic [RW-1:0] code_reg, code_next;
    logic [CW-1:0] bit_index_reg, bit_index_next;
    logic [CW-1:0] bits_since_reg, bits_since_next;
    logic          repeat_pending_reg, repeat_pending_next;

    // result register
    logic          out_valid_reg;
    logic          key_event_reg, key_event_next;
    logic          was_repeat_reg, was_repeat_next;
    logic [RW-1:0] raw_code_reg;
    logic [7:0]    key_code_reg, key_code_next;
    logic          code_ok_reg, code_ok_next;

    logic in_xfer;

    assign in_stall  = out_valid_reg && out_stall;
    assign in_xfer   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_mark_low_reg  <= irpwd_pkg::RST_LEADER_MARK_LOW;
            leader_space_low_reg <= irpwd_pkg::RST_LEADER_SPACE_LOW;
            repeat_space_low_reg <= irpwd_pkg::RST_REPEAT_SPACE_LOW;
            long_window_reg      <= irpwd_pkg::RST_LONG_WINDOW;
            bit_mark_low_reg     <= irpwd_pkg::RST_BIT_MARK_LOW;
            zero_space_low_reg   <= irpwd_pkg::RST_ZERO_SPACE_LOW;
            one_space_low_reg    <= irpwd_pkg::RST_ONE_SPACE_LOW;
            short_window_reg     <= irpwd_pkg::RST_SHORT_WINDOW;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                irpwd_pkg::CFG_LEADER_MARK_LOW:  leader_mark_low_reg  <= cfg_data;
                irpwd_pkg::CFG_LEADER_SPACE_LOW: leader_space_low_reg <= cfg_data;
                irpwd_pkg::CFG_REPEAT_SPACE_LOW: repeat_space_low_reg <= cfg_data;
                irpwd_pkg::CFG_LONG_WINDOW:      long_window_reg      <= cfg_data;
                irpwd_pkg::CFG_BIT_MARK_LOW:     bit_mark_low_reg     <= cfg_data;
                irpwd_pkg::CFG_ZERO_SPACE_LOW:   zero_space_low_reg   <= cfg_data;
                irpwd_pkg::CFG_ONE_SPACE_LOW:    one_space_low_reg    <= cfg_data;
                irpwd_pkg::CFG_SHORT_WINDOW:     short_window_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        logic lead_mark, lead_hit, rep_hit, bit_mark, zero_hit, one_hit, put;
        logic event_hit;
        logic [7:0] hi_byte, lo_byte;

        phase_next = ~phase_reg;
        mark_next  = phase_next ? mark_reg : edge_ticks;
        space_next = phase_next ? edge_ticks : space_reg;

        code_next           = code_reg;
        bit_index_next      = bit_index_reg;
        bits_since_next     = bits_since_reg;
        repeat_pending_next = repeat_pending_reg;

        lead_mark = in_window(mark_next, leader_mark_low_reg, long_window_reg);
        lead_hit  = lead_mark &&
                    in_window(space_next, leader_space_low_reg, long_window_reg);
        rep_hit   = lead_mark &&
                    in_window(space_next, repeat_space_low_reg, long_window_reg);

        priority if (lead_hit)
        begin
            code_next           = '0;
            repeat_pending_next = 1'b0;
            bit_index_next      = '0;
        end
        else if (rep_hit)
        begin
            repeat_pending_next = 1'b1;
        end

        // zero range wins where the two overlap
        bit_mark = phase_next && in_window(mark_next, bit_mark_low_reg, short_window_reg);
        zero_hit = in_window(space_next, zero_space_low_reg, short_window_reg);
        one_hit  = in_window(space_next, one_space_low_reg, short_window_reg);
        put      = bit_mark && (zero_hit || one_hit);

        if (put)
        begin
            if (bit_index_next < irpwd_pkg::CODE_COUNT)
            begin
                code_next[bit_index_next[$clog2(RW)-1:0]] = !zero_hit;
            end
            if (bit_index_next != irpwd_pkg::COUNT_MAX)
            begin
                bit_index_next = bit_index_next + 1'b1;
            end
            if (bits_since_next != irpwd_pkg::COUNT_MAX)
            begin
                bits_since_next = bits_since_next + 1'b1;
            end
        end

        event_hit       = (bits_since_next == irpwd_pkg::CODE_COUNT) || repeat_pending_next;
        key_event_next  = event_hit;
        was_repeat_next = event_hit && repeat_pending_next;
        if (event_hit)
        begin
            repeat_pending_next = 1'b0;
            bits_since_next     = '0;
        end

        hi_byte       = code_next[31:24];
        lo_byte       = code_next[23:16];
        code_ok_next  = (hi_byte ^ lo_byte) == irpwd_pkg::COMPLEMENT_MASK;
        key_code_next = code_ok_next ? lo_byte : 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= 1'b1;
            mark_reg           <= '0;
            space_reg          <= '0;
            code_reg           <= '0;
            bit_index_reg      <= '0;
            bits_since_reg     <= '0;
            repeat_pending_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg          <= phase_next;
            mark_reg           <= mark_next;
            space_reg          <= space_next;
            code_reg           <= code_next;
            bit_index_reg      <= bit_index_next;
            bits_since_reg     <= bits_since_next;
            repeat_pending_reg <= repeat_pending_next;
        end
    end

    // hold the result while the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_xfer)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            key_event_reg  <= key_event_next;
            was_repeat_reg <= was_repeat_next;
            raw_code_reg   <= code_next;
            key_code_reg   <= key_code_next;
            code_ok_reg    <= code_ok_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_event  = key_event_reg;
    assign was_repeat = was_repeat_reg;
    assign raw_code   = raw_code_reg;
    assign key_code   = key_code_reg;
    assign code_ok    = code_ok_reg;

endmodule

`default_nettype wire

// File: rtl/core/irpwd_checker.sv
// ----------------------------------------------------------------------------
// irpwd_checker
// Port-level checks for the infrared pulse-width decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module irpwd_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_stall,
    input wire logic [irpwd_pkg::TICK_W-1:0]      edge_ticks,
    input wire logic                              out_valid,
    input wire logic                              out_stall,
    input wire logic                              key_event,
    input wire logic                              was_repeat,
    input wire logic [irpwd_pkg::RAW_W-1:0]       raw_code,
    input wire logic [7:0]                        key_code,
    input wire logic                              code_ok,
    input wire logic                              cfg_valid,
    input wire logic                              cfg_ready,
    input wire logic [irpwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input wire logic [irpwd_pkg::TICK_W-1:0]      cfg_data
);

    logic unused_ok;
    assign unused_ok = ^{edge_ticks, cfg_valid, cfg_ready, cfg_index, cfg_data};

    // a repeat flag only comes with an event
    a_repeat_needs_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_repeat |-> key_event)
        else $error("was_repeat without key_event");

    // code_ok agrees with the top two bytes of raw_code
    a_code_ok_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> code_ok ==
            ((raw_code[31:24] ^ raw_code[23:16]) == irpwd_pkg::COMPLEMENT_MASK))
        else $error("code_ok disagrees with raw_code");

    // key_code is the checked byte or zero
    a_key_code_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (code_ok ? (key_code == raw_code[23:16]) : (key_code == 8'h00)))
        else $error("key_code inconsistent with code_ok");

    // every transfer in shows a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("no result after an input transfer");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(raw_code) && $stable(key_event))
        else $error("stalled result changed");

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .edge_ticks (edge_ticks),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .key_event  (key_event),
    .was_repeat (was_repeat),
    .raw_code   (raw_code),
    .key_code   (key_code),
    .code_ok    (code_ok),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);

`default_nettype wire

// File: tb/sv/ir_pulse_width_decoder_tb.sv
// ----------------------------------------------------------------------------
// ir_pulse_width_decoder_tb
// Self-checking bench for the infrared pulse-width decoder. Mark/space
// durations are fed as leader, data and repeat frames plus noise, under
// several threshold settings and idle patterns. Every result is compared
// against a cycle-free decode of the same durations kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_pulse_width_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF        = 4;
    localparam int RESET_CYCLES    = 2;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int MAX_REPORTS     = 10;
    localparam int LONG_HOLD       = 400;
    localparam int NUM_PHASES      = 10;
    localparam int FULL_BUDGET     = 170;
    localparam int EXTREME_BUDGET  = 80;
    localparam int NUM_REGS        = 8;
    localparam int CFG_SPARE_FIRST = int'(irpwd_pkg::CFG_SHORT_WINDOW) + 1;
    localparam int CFG_SPARE_LAST  = (1 << irpwd_pkg::CFG_INDEX_W) - 1;
    localparam int TICK_MAX        = (1 << irpwd_pkg::TICK_W) - 1;

    typedef enum int {
        TM_RESET,
        TM_SCALED,
        TM_OVERLAP,
        TM_MAX_WINDOW,
        TM_ALL_ONES,
        TM_ALL_ZERO,
        TM_TIGHT,
        TM_DEFAULTS
    } timing_mode_t;

    typedef struct packed {
        logic                        key_event;
        logic                        was_repeat;
        logic [irpwd_pkg::RAW_W-1:0] raw_code;
        logic [7:0]                  key_code;
        logic                        code_ok;
    } key_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_stall;
    logic [irpwd_pkg::TICK_W-1:0]      edge_ticks = '0;
    logic                              out_valid;
    logic                              out_stall = 1'b0;
    logic                              key_event;
    logic                              was_repeat;
    logic [irpwd_pkg::RAW_W-1:0]       raw_code;
    logic [7:0]                        key_code;
    logic                              code_ok;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [irpwd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [irpwd_pkg::TICK_W-1:0]      cfg_data = '0;

    ir_pulse_width_decoder u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .edge_ticks (edge_ticks),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .key_event  (key_event),
        .was_repeat (was_repeat),
        .raw_code   (raw_code),
        .key_code   (key_code),
        .code_ok    (code_ok),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // Threshold registers as the bench believes them, and the next setting.
    logic [irpwd_pkg::TICK_W-1:0] thr [NUM_REGS] = '{
        irpwd_pkg::RST_LEADER_MARK_LOW, irpwd_pkg::RST_LEADER_SPACE_LOW,
        irpwd_pkg::RST_REPEAT_SPACE_LOW, irpwd_pkg::RST_LONG_WINDOW,
        irpwd_pkg::RST_BIT_MARK_LOW, irpwd_pkg::RST_ZERO_SPACE_LOW,
        irpwd_pkg::RST_ONE_SPACE_LOW, irpwd_pkg::RST_SHORT_WINDOW};
    logic [irpwd_pkg::TICK_W-1:0] next_thr [NUM_REGS];

    // Decode state
    logic                          dec_phase = 1'b1;
    logic [irpwd_pkg::TICK_W-1:0]  dec_mark = '0;
    logic [irpwd_pkg::TICK_W-1:0]  dec_space = '0;
    logic [irpwd_pkg::RAW_W-1:0]   dec_code = '0;
    logic [irpwd_pkg::COUNT_W-1:0] dec_bit_idx = '0;
    logic [irpwd_pkg::COUNT_W-1:0] dec_bits_since = '0;
    logic                          dec_repeat = 1'b0;

    logic [irpwd_pkg::TICK_W-1:0] tick_queue [$];
    key_result_t                  decode_queue [$];

    logic in_xfer = 1'b0;
    logic send_hold = 1'b0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    int   hold_reqs = 0;
    int   hold_served = 0;
    int   hold_left = 0;
    int   fail_count = 0;
    int   cycle_count = 0;

    int send_idle_tbl [4] = '{0, 87, 0, 15};
    int recv_stall_tbl [4] = '{0, 0, 87, 15};

    timing_mode_t phase_plan [NUM_PHASES] = '{TM_RESET, TM_SCALED, TM_OVERLAP, TM_ALL_ONES,
                                              TM_SCALED, TM_ALL_ZERO, TM_MAX_WINDOW,
                                              TM_TIGHT, TM_DEFAULTS, TM_SCALED};

    // Durations on and near the range boundaries, taken from the power-on thresholds.
    logic [irpwd_pkg::TICK_W-1:0] directed_ticks [24] = '{
        16'd0,    16'd65535,            // field extremes
        16'd4001, 16'd2001,             // leader just inside
        16'd201,  16'd201,              // zero bit, lower edges
        16'd299,  16'd899,              // one bit, upper edges
        16'd300,  16'd850,              // bit mark at upper bound
        16'd200,  16'd250,              // bit mark at lower bound
        16'd250,  16'd300,              // zero space at upper bound
        16'd4999, 16'd7001,             // repeat frame
        16'd4000, 16'd7500,             // leader mark at lower bound
        16'd4500, 16'd8000,             // repeat space at upper bound
        16'd4500, 16'd3000,             // leader space at upper bound
        16'd4500, 16'd2999              // leader again
    };

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    function automatic bit in_window(logic [irpwd_pkg::TICK_W-1:0] v,
                                     logic [irpwd_pkg::TICK_W-1:0] lo,
                                     logic [irpwd_pkg::TICK_W-1:0] win);
        logic [irpwd_pkg::TICK_W:0] top;
        top = {1'b0, lo} + {1'b0, win};
        return (v > lo) && ({1'b0, v} < top);
    endfunction

    // Advance the decode state by one duration and return the result it gives.
    function automatic key_result_t decode_edge(logic [irpwd_pkg::TICK_W-1:0] ticks);
        key_result_t r;
        logic        lead_mark;
        logic        got_bit;
        logic        bit_val;
        r = '0;
        got_bit = 1'b0;
        bit_val = 1'b0;
        dec_phase = ~dec_phase;
        if (!dec_phase)
            dec_mark = ticks;
        else
            dec_space = ticks;

        lead_mark = in_window(dec_mark, thr[irpwd_pkg::CFG_LEADER_MARK_LOW],
                              thr[irpwd_pkg::CFG_LONG_WINDOW]);
        if (lead_mark && in_window(dec_space, thr[irpwd_pkg::CFG_LEADER_SPACE_LOW],
                                   thr[irpwd_pkg::CFG_LONG_WINDOW]))
        begin
            dec_code = '0;
            dec_repeat = 1'b0;
            dec_bit_idx = '0;
        end
        else if (lead_mark && in_window(dec_space, thr[irpwd_pkg::CFG_REPEAT_SPACE_LOW],
                                        thr[irpwd_pkg::CFG_LONG_WINDOW]))
        begin
            dec_repeat = 1'b1;
        end

        if (dec_phase && in_window(dec_mark, thr[irpwd_pkg::CFG_BIT_MARK_LOW],
                                   thr[irpwd_pkg::CFG_SHORT_WINDOW]))
        begin
            // zero range is tested first, so it wins where the two overlap
            if (in_window(dec_space, thr[irpwd_pkg::CFG_ZERO_SPACE_LOW],
                          thr[irpwd_pkg::CFG_SHORT_WINDOW]))
                got_bit = 1'b1;
            else if (in_window(dec_space, thr[irpwd_pkg::CFG_ONE_SPACE_LOW],
                               thr[irpwd_pkg::CFG_SHORT_WINDOW]))
            begin
                got_bit = 1'b1;
                bit_val = 1'b1;
            end
        end

        if (got_bit)
        begin
            if (dec_bit_idx < irpwd_pkg::CODE_COUNT)
                dec_code[dec_bit_idx[4:0]] = bit_val;
            if (dec_bit_idx != irpwd_pkg::COUNT_MAX)
                dec_bit_idx = dec_bit_idx + 1'b1;
            if (dec_bits_since != irpwd_pkg::COUNT_MAX)
                dec_bits_since = dec_bits_since + 1'b1;
        end

        if (dec_bits_since == irpwd_pkg::CODE_COUNT || dec_repeat)
        begin
            r.key_event = 1'b1;
            r.was_repeat = dec_repeat;
            dec_repeat = 1'b0;
            dec_bits_since = '0;
        end

        r.raw_code = dec_code;
        r.code_ok = (dec_code[31:24] ^ dec_code[23:16]) == irpwd_pkg::COMPLEMENT_MASK;
        r.key_code = r.code_ok ? dec_code[23:16] : 8'h00;
        return r;
    endfunction

    // Random duration strictly inside (lo, lo + win); any value if the range is empty.
    function automatic logic [irpwd_pkg::TICK_W-1:0] pick_in(
            logic [irpwd_pkg::TICK_W-1:0] lo,
            logic [irpwd_pkg::TICK_W-1:0] win);
        int lo_i;
        int span;
        lo_i = int'(lo);
        span = int'(win) - 1;
        if (span > TICK_MAX - lo_i)
            span = TICK_MAX - lo_i;
        if (span < 1)
            return irpwd_pkg::TICK_W'($urandom);
        return irpwd_pkg::TICK_W'(lo_i + int'($urandom_range(1, span)));
    endfunction

    function automatic logic [irpwd_pkg::TICK_W-1:0] scaled(
            logic [irpwd_pkg::TICK_W-1:0] base, int num);
        return irpwd_pkg::TICK_W'((int'(base) * num) / 16);
    endfunction

    task automatic push_frame(int nbits, logic [31:0] data, bit rpt);
        tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_LEADER_MARK_LOW],
                                     thr[irpwd_pkg::CFG_LONG_WINDOW]));
        if (rpt)
            tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_REPEAT_SPACE_LOW],
                                         thr[irpwd_pkg::CFG_LONG_WINDOW]));
        else
            tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_LEADER_SPACE_LOW],
                                         thr[irpwd_pkg::CFG_LONG_WINDOW]));
        for (int i = 0; i < nbits; i++)
        begin
            tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_BIT_MARK_LOW],
                                         thr[irpwd_pkg::CFG_SHORT_WINDOW]));
            if (data[i % 32])
                tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_ONE_SPACE_LOW],
                                             thr[irpwd_pkg::CFG_SHORT_WINDOW]));
            else
                tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_ZERO_SPACE_LOW],
                                             thr[irpwd_pkg::CFG_SHORT_WINDOW]));
        end
        // stop mark and the gap to the next frame
        tick_queue.push_back(pick_in(thr[irpwd_pkg::CFG_BIT_MARK_LOW],
                                     thr[irpwd_pkg::CFG_SHORT_WINDOW]));
        tick_queue.push_back(irpwd_pkg::TICK_W'($urandom));
    endtask

    task automatic fill_random(int budget);
        int          start;
        int          pick;
        int          k;
        logic [31:0] data;
        start = tick_queue.size();
        while (tick_queue.size() - start < budget)
        begin
            pick = $urandom_range(0, 99);
            data = $urandom;
            if ($urandom_range(0, 1))
                data[31:24] = ~data[23:16];
            if (pick < 60)
                push_frame(32, data, 1'b0);
            else if (pick < 72)
                push_frame(0, data, 1'b1);
            else if (pick < 78)
                push_frame($urandom_range(0, 31), data, 1'b0);
            else if (pick < 84)
                push_frame($urandom_range(33, 72), data, 1'b0);    // bit index may reach cap
            else
            begin
                // noise burst, often right on a range boundary
                repeat ($urandom_range(1, 6))
                begin
                    k = $urandom_range(0, NUM_REGS - 1);
                    case ($urandom_range(0, 3))
                        0: tick_queue.push_back(thr[k]);
                        1: tick_queue.push_back(thr[k] + thr[irpwd_pkg::CFG_SHORT_WINDOW]);
                        2: tick_queue.push_back(thr[k] + thr[irpwd_pkg::CFG_LONG_WINDOW]);
                        default: tick_queue.push_back(irpwd_pkg::TICK_W'($urandom));
                    endcase
                end
            end
        end
    endtask

    task automatic choose_thresholds(timing_mode_t mode);
        int num;
        bit is_window;
        num = $urandom_range(4, 60);
        for (int k = 0; k < NUM_REGS; k++)
        begin
            is_window = (k == irpwd_pkg::CFG_LONG_WINDOW) ||
                        (k == irpwd_pkg::CFG_SHORT_WINDOW);
            case (mode)
                TM_MAX_WINDOW: next_thr[k] = is_window ? '1 : '0;
                TM_ALL_ONES:   next_thr[k] = '1;
                TM_ALL_ZERO:   next_thr[k] = '0;
                TM_TIGHT:      next_thr[k] = is_window ? irpwd_pkg::TICK_W'(2)
                    : irpwd_pkg::TICK_W'($urandom_range(0, TICK_MAX - 2));
                default:       next_thr[k] = thr[k];
            endcase
        end
        if (mode == TM_SCALED || mode == TM_OVERLAP)
        begin
            next_thr[irpwd_pkg::CFG_LEADER_MARK_LOW]  =
                scaled(irpwd_pkg::RST_LEADER_MARK_LOW, num);
            next_thr[irpwd_pkg::CFG_LEADER_SPACE_LOW] =
                scaled(irpwd_pkg::RST_LEADER_SPACE_LOW, num);
            next_thr[irpwd_pkg::CFG_REPEAT_SPACE_LOW] =
                scaled(irpwd_pkg::RST_REPEAT_SPACE_LOW, num);
            next_thr[irpwd_pkg::CFG_LONG_WINDOW]      =
                scaled(irpwd_pkg::RST_LONG_WINDOW, num);
            next_thr[irpwd_pkg::CFG_BIT_MARK_LOW]     =
                scaled(irpwd_pkg::RST_BIT_MARK_LOW, num);
            next_thr[irpwd_pkg::CFG_ZERO_SPACE_LOW]   =
                scaled(irpwd_pkg::RST_ZERO_SPACE_LOW, num);
            next_thr[irpwd_pkg::CFG_ONE_SPACE_LOW]    =
                scaled(irpwd_pkg::RST_ONE_SPACE_LOW, num);
            next_thr[irpwd_pkg::CFG_SHORT_WINDOW]     =
                scaled(irpwd_pkg::RST_SHORT_WINDOW, num);
        end
        if (mode == TM_OVERLAP)
            next_thr[irpwd_pkg::CFG_ONE_SPACE_LOW] =
                next_thr[irpwd_pkg::CFG_ZERO_SPACE_LOW] + irpwd_pkg::TICK_W'(
                    $urandom_range(0, int'(next_thr[irpwd_pkg::CFG_SHORT_WINDOW]) - 1));
        if (mode == TM_DEFAULTS)
        begin
            next_thr[irpwd_pkg::CFG_LEADER_MARK_LOW]  = irpwd_pkg::RST_LEADER_MARK_LOW;
            next_thr[irpwd_pkg::CFG_LEADER_SPACE_LOW] = irpwd_pkg::RST_LEADER_SPACE_LOW;
            next_thr[irpwd_pkg::CFG_REPEAT_SPACE_LOW] = irpwd_pkg::RST_REPEAT_SPACE_LOW;
            next_thr[irpwd_pkg::CFG_LONG_WINDOW]      = irpwd_pkg::RST_LONG_WINDOW;
            next_thr[irpwd_pkg::CFG_BIT_MARK_LOW]     = irpwd_pkg::RST_BIT_MARK_LOW;
            next_thr[irpwd_pkg::CFG_ZERO_SPACE_LOW]   = irpwd_pkg::RST_ZERO_SPACE_LOW;
            next_thr[irpwd_pkg::CFG_ONE_SPACE_LOW]    = irpwd_pkg::RST_ONE_SPACE_LOW;
            next_thr[irpwd_pkg::CFG_SHORT_WINDOW]     = irpwd_pkg::RST_SHORT_WINDOW;
        end
    endtask

    // Write next_thr into the block, then one write to an unused index.
    task automatic write_thresholds();
        for (int k = 0; k < NUM_REGS; k++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= irpwd_pkg::cfg_index_t'(k);
            cfg_data  <= next_thr[k];
            do @(posedge clk); while (!cfg_ready);
            thr[k] = next_thr[k];
        end
        @(negedge clk);
        cfg_index <= irpwd_pkg::CFG_INDEX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST));
        cfg_data  <= irpwd_pkg::TICK_W'($urandom);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (tick_queue.size() != 0 || in_valid || decode_queue.size() != 0);
    endtask

    // Sender: offer the next duration once the previous one has transferred.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_xfer))
        begin
            if (tick_queue.size() != 0 && !send_hold &&
                $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid   <= 1'b1;
                edge_ticks <= tick_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stall, or a long hold when one is requested.
    always @(negedge clk)
    begin
        if (hold_reqs != hold_served)
        begin
            hold_left = LONG_HOLD;
            hold_served++;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer.
    always @(posedge clk)
    begin
        key_result_t got;
        key_result_t exp;
        in_xfer <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            decode_queue.push_back(decode_edge(edge_ticks));
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{key_event, was_repeat, raw_code, key_code, code_ok};
            if (decode_queue.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("[%0t] result with nothing expected: raw_code %08h",
                             $realtime, raw_code);
            end
            else
            begin
                exp = decode_queue.pop_front();
                if (got.key_event !== exp.key_event || got.was_repeat !== exp.was_repeat ||
                    got.raw_code !== exp.raw_code || got.key_code !== exp.key_code ||
                    got.code_ok !== exp.code_ok)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"[%0t] mismatch (exp/act): key_event %0b/%0b ",
                                  "was_repeat %0b/%0b raw_code %08h/%08h ",
                                  "key_code %02h/%02h code_ok %0b/%0b"},
                                 $realtime, exp.key_event, got.key_event,
                                 exp.was_repeat, got.was_repeat, exp.raw_code, got.raw_code,
                                 exp.key_code, got.key_code, exp.code_ok, got.code_ok);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** ir_pulse_width_decoder: FAILED **");
            $finish;
        end
    end

    initial
    begin
        int budget;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (phase_plan[p] == TM_RESET)
            begin
                foreach (directed_ticks[i])
                    tick_queue.push_back(directed_ticks[i]);
            end
            else
            begin
                choose_thresholds(phase_plan[p]);
                write_thresholds();
            end
            budget = (phase_plan[p] == TM_ALL_ONES || phase_plan[p] == TM_ALL_ZERO ||
                      phase_plan[p] == TM_MAX_WINDOW) ? EXTREME_BUDGET : FULL_BUDGET;
            fill_random(budget);

            @(posedge clk);
            send_idle_pct  = send_idle_tbl[p % 4];
            recv_stall_pct = recv_stall_tbl[p % 4];

            // hold the output while input keeps coming, so the block backs up
            if (p == 4)
                hold_reqs++;

            // pause input mid-phase until every result has come back
            if (p == 8)
            begin
                do @(posedge clk); while (tick_queue.size() > budget / 2);
                send_hold = 1'b1;
                do @(posedge clk); while (in_valid || decode_queue.size() != 0);
                send_hold = 1'b0;
            end

            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && decode_queue.size() == 0)
            $display("** ir_pulse_width_decoder: PASSED **");
        else
            $display("** ir_pulse_width_decoder: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
